// File: design/pprm_pkg.sv
// ----------------------------------------------------------------------------
// pprm_pkg
// Shared widths, reset values and codes for the pulse period rpm meter.
// ----------------------------------------------------------------------------
package pprm_pkg;

   localparam int TIME_W    = 32;
   localparam int CFG_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int STEP_W    = $clog2(TIME_W);

   localparam logic [CFG_W-1:0]  DEBOUNCE_RESET = CFG_W'(6315);
   localparam logic [CFG_W-1:0]  TIMEOUT_RESET  = CFG_W'(1000000);
   localparam logic [CFG_W-1:0]  TPM_RESET      = CFG_W'(60000000);
   localparam logic [TIME_W-1:0] RPM_SENTINEL   = TIME_W'(9999);

   localparam logic KIND_EDGE   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_TIMEOUT  = 2'd1,
      CSR_TPM      = 2'd2
   } csr_index_type;

endpackage

// File: design/pprm_req_if.sv
// ----------------------------------------------------------------------------
// pprm_req_if
// Input channel: spark edge or sample request with its timestamp.
// ----------------------------------------------------------------------------
interface pprm_req_if;
   import pprm_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [TIME_W-1:0] time_us;

   modport source (output valid, output kind, output time_us, input ready);
   modport sink   (input valid, input kind, input time_us, output ready);
endinterface

// File: design/pprm_rsp_if.sv
// ----------------------------------------------------------------------------
// pprm_rsp_if
// Result channel: rpm reading with running and changed flags.
// ----------------------------------------------------------------------------
interface pprm_rsp_if;
   import pprm_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] rpm;
   logic              running;
   logic              changed;

   modport source (output valid, output rpm, output running, output changed,
                   input ready);
   modport sink   (input valid, input rpm, input running, input changed,
                   output ready);
endinterface

// File: design/pulse_period_rpm_meter.sv
// ----------------------------------------------------------------------------
// pulse_period_rpm_meter
// Period-based tachometer: debounced spark edges set the period, sample
// requests return ticks_per_minute / period through a radix-2 divider.
// ----------------------------------------------------------------------------
// A spark edge is accepted in the idle state and gives no result. A sample
// request that finds the engine running first accepts and checks the timeout,
// then runs the restoring divider (one quotient bit per cycle), and then
// loads the output register once that register is free. A stopped engine skips
// the divider and goes straight to the output load. The input is not ready while
// a sample is in progress; the output register lets the next item be accepted
// while a result waits for its transfer. Configuration writes take effect at
// once and should be made while no sample is in progress.
module pulse_period_rpm_meter (
   input  logic                            clock,
   input  logic                            reset,
   pprm_req_if.sink                        req,
   pprm_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [pprm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pprm_pkg::CFG_W-1:0]      csr_wdata
);
   import pprm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [CFG_W-1:0]    debounce_ff, debounce_in;
   logic [CFG_W-1:0]    timeout_ff, timeout_in;
   logic [CFG_W-1:0]    tpm_ff, tpm_in;
   logic [TIME_W-1:0]   last_edge_ff, last_edge_in;
   logic [TIME_W-1:0]   period_ff, period_in;
   logic                running_ff, running_in;
   logic [TIME_W-1:0]   last_rpm_ff, last_rpm_in;
   logic [TIME_W:0]     rem_ff, rem_in;
   logic [TIME_W-1:0]   quot_ff, quot_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]   rsp_rpm_ff, rsp_rpm_in;
   logic                rsp_running_ff, rsp_running_in;
   logic                rsp_changed_ff, rsp_changed_in;

   logic                req_xfer;
   logic [TIME_W-1:0]   elapsed;
   logic [TIME_W:0]     rem_shift;
   logic                rem_ge;
   logic                out_free;

   assign req.ready   = (state_ff == ST_IDLE);
   assign req_xfer    = req.valid && req.ready;
   assign elapsed     = req.time_us - last_edge_ff;
   assign out_free    = !rsp_valid_ff || rsp.ready;

   // restoring divide step: bring down the next dividend bit
   assign rem_shift   = {rem_ff[TIME_W-1:0], quot_ff[TIME_W-1]};
   assign rem_ge      = (rem_shift >= {1'b0, period_ff});

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.rpm     = rsp_rpm_ff;
   assign rsp.running = rsp_running_ff;
   assign rsp.changed = rsp_changed_ff;

   always_comb begin
      state_in       = state_ff;
      debounce_in    = debounce_ff;
      timeout_in     = timeout_ff;
      tpm_in         = tpm_ff;
      last_edge_in   = last_edge_ff;
      period_in      = period_ff;
      running_in     = running_ff;
      last_rpm_in    = last_rpm_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_rpm_in     = rsp_rpm_ff;
      rsp_running_in = rsp_running_ff;
      rsp_changed_in = rsp_changed_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_in = csr_wdata;
            CSR_TIMEOUT:  timeout_in  = csr_wdata;
            CSR_TPM:      tpm_in      = csr_wdata;
            default:      ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req.kind == KIND_EDGE) begin
                  if (elapsed > debounce_ff) begin
                     period_in    = elapsed;
                     last_edge_in = req.time_us;
                  end
               end else if (elapsed > timeout_ff || period_ff == '0) begin
                  running_in = 1'b0;
                  period_in  = '0;
                  quot_in    = '0;
                  state_in   = ST_FINISH;
               end else begin
                  running_in = 1'b1;
                  rem_in     = '0;
                  quot_in    = tpm_ff;
                  step_in    = '0;
                  state_in   = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in  = rem_ge ? (rem_shift - {1'b0, period_ff}) : rem_shift;
            quot_in = {quot_ff[TIME_W-2:0], rem_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(TIME_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_rpm_in     = quot_ff;
               rsp_running_in = running_ff;
               rsp_changed_in = (quot_ff != last_rpm_ff);
               last_rpm_in    = quot_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         debounce_ff  <= DEBOUNCE_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         tpm_ff       <= TPM_RESET;
         last_edge_ff <= '0;
         period_ff    <= '0;
         running_ff   <= 1'b0;
         last_rpm_ff  <= RPM_SENTINEL;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         debounce_ff  <= debounce_in;
         timeout_ff   <= timeout_in;
         tpm_ff       <= tpm_in;
         last_edge_ff <= last_edge_in;
         period_ff    <= period_in;
         running_ff   <= running_in;
         last_rpm_ff  <= last_rpm_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff         <= rem_in;
      quot_ff        <= quot_in;
      rsp_rpm_ff     <= rsp_rpm_in;
      rsp_running_ff <= rsp_running_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   // divider never runs on a zero period
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> period_ff != '0)
      else $error("divide started with zero period");

   // restoring invariant: partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < {1'b0, period_ff})
      else $error("partial remainder out of range");

   // last divide step hands over to the output load
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE && step_ff == STEP_W'(TIME_W - 1) |=> state_ff == ST_FINISH)
      else $error("divider overran its step count");

   // a stopped reading always reports zero rpm
   a_stopped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_running_ff |-> rsp_rpm_ff == '0)
      else $error("stopped result with nonzero rpm");

   // no input transfer while a sample is in progress
   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && req_xfer && req.kind == KIND_SAMPLE |=> !req.ready)
      else $error("input ready during a sample");

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse period rpm meter. Spark edges and sample
// requests go in over the request channel under random gaps; a local model of
// the debounce, timeout and divide logic predicts every reading, and each
// reading transfer is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import pprm_pkg::*;

   localparam int GAP_MAX        = 17;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 112;
   localparam int PRESSURE_ITEMS = 40;
   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0] rpm;
      logic              running;
      logic              changed;
   } reading_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   pprm_req_if req_ch ();
   pprm_rsp_if rsp_ch ();

   pulse_period_rpm_meter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // tachometer model state
   logic [CFG_W-1:0]  cfg_debounce;
   logic [CFG_W-1:0]  cfg_timeout;
   logic [CFG_W-1:0]  cfg_tpm;
   logic [TIME_W-1:0] edge_stamp;
   logic [TIME_W-1:0] period_us;
   logic [TIME_W-1:0] last_rpm;
   reading_type       expected_readings[$];

   logic [TIME_W-1:0] stamp_now;
   bit                steady;
   int                hold_request;
   int                items_sent;
   int                readings_seen;
   int                csr_writes;
   int                mismatches;
   int                idle_cycles;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function void predict_item(input logic kind, input logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] elapsed;
      reading_type       r;
      elapsed = stamp - edge_stamp;
      if (kind == KIND_EDGE) begin
         if (elapsed > cfg_debounce) begin
            period_us  = elapsed;
            edge_stamp = stamp;
         end
      end else begin
         if (elapsed > cfg_timeout || period_us == '0) begin
            period_us = '0;
            r.rpm     = '0;
            r.running = 1'b0;
         end else begin
            r.rpm     = cfg_tpm / period_us;
            r.running = 1'b1;
         end
         r.changed = (r.rpm != last_rpm);
         last_rpm  = r.rpm;
         expected_readings.push_back(r);
      end
   endfunction

   // valid stays high on return; a later call with a gap, or wait_for_drain, drops it
   task send_item(input logic kind, input logic [TIME_W-1:0] stamp);
      int gap;
      gap = steady ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.time_us <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_item(kind, stamp);
      items_sent++;
   endtask

   task wait_for_drain();
      req_ch.valid <= 1'b0;
      while (expected_readings.size() > 0) @(posedge clock);
      // an edge may still be in flight after the last reading
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_csr(input logic [CSR_IDX_W-1:0] reg_index, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (reg_index)
         CSR_DEBOUNCE: cfg_debounce = value;
         CSR_TIMEOUT:  cfg_timeout  = value;
         CSR_TPM:      cfg_tpm      = value;
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task apply_setting(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] timeout,
                      input logic [CFG_W-1:0] tpm);
      write_csr(CSR_DEBOUNCE, debounce);
      write_csr(CSR_TIMEOUT, timeout);
      write_csr(CSR_TPM, tpm);
   endtask

   // period that clears the debounce window, scaled to a random magnitude
   function logic [TIME_W-1:0] pick_period();
      longint lo;
      longint hi;
      longint span;
      longint cap;
      lo = longint'(cfg_debounce) + 1;
      hi = longint'(cfg_timeout);
      if (hi < lo) hi = lo;
      span = hi - lo;
      cap  = (longint'(1) << $urandom_range(0, 31)) - 1;
      if (span > cap) span = cap;
      return TIME_W'(lo + longint'($urandom_range(0, 32'(span))));
   endfunction

   task run_burst();
      int                style;
      int                n_samples;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] offset;
      style = $urandom_range(0, 9);
      if (style < 7) begin
         // regular spark train with bounces and samples in between
         period = pick_period();
         repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 3) == 0)
               send_item(KIND_EDGE, stamp_now + $urandom_range(0, cfg_debounce));
            stamp_now += period + $urandom_range(0, 2);
            send_item(KIND_EDGE, stamp_now);
            n_samples = $urandom_range(0, 2);
            repeat (n_samples) send_item(KIND_SAMPLE, stamp_now + $urandom_range(0, period));
         end
      end else if (style == 7) begin
         // sample right at or past the timeout boundary
         offset = ($urandom_range(0, 2) == 2) ? $urandom() : $urandom_range(0, 1);
         send_item(KIND_SAMPLE, edge_stamp + cfg_timeout + offset);
      end else begin
         repeat ($urandom_range(1, 4))
            send_item(1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) ? $urandom() : stamp_now + $urandom_range(0, 20000));
      end
   endtask

   task test_directed_defaults();
      send_item(KIND_SAMPLE, 32'd0);        // no period yet
      send_item(KIND_EDGE,   32'd20000);    // first edge takes its own stamp as period
      send_item(KIND_EDGE,   32'd20100);    // bounce
      send_item(KIND_SAMPLE, 32'd25000);
      send_item(KIND_EDGE,   32'd26315);    // exactly at the debounce window
      send_item(KIND_EDGE,   32'd26316);
      send_item(KIND_SAMPLE, 32'd26400);
      send_item(KIND_EDGE,   32'd32632);
      send_item(KIND_SAMPLE, 32'd33000);    // same rpm, no change
      send_item(KIND_SAMPLE, 32'd1032633);  // timed out
      send_item(KIND_SAMPLE, 32'd1032634);  // period already cleared
   endtask

   task test_directed_extremes();
      wait_for_drain();
      apply_setting('0, '1, '1);
      write_csr(CSR_SPARE, 32'd7);
      send_item(KIND_EDGE,   32'hFFFF_FFFF);
      send_item(KIND_EDGE,   32'hFFFF_FFFF);  // same stamp, zero window still rejects
      send_item(KIND_EDGE,   32'h0000_0000);  // wraps, period of one tick
      send_item(KIND_SAMPLE, 32'h0000_0005);
      send_item(KIND_EDGE,   32'h8000_0000);
      send_item(KIND_SAMPLE, 32'h8000_0001);
      wait_for_drain();
      apply_setting('0, 32'd1, '0);
      send_item(KIND_EDGE,   32'h8000_0010);
      send_item(KIND_SAMPLE, 32'h8000_0011);  // running with zero dividend
      send_item(KIND_SAMPLE, 32'h8000_0012);  // one tick past the timeout
      wait_for_drain();
      apply_setting('1, '1, TPM_RESET);
      send_item(KIND_EDGE,   32'h1234_5678);  // full window, never taken
      send_item(KIND_SAMPLE, 32'h1234_5679);
   endtask

   task test_random_traffic();
      int goal;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drain();
         case (phase)
            0: apply_setting(DEBOUNCE_RESET, TIMEOUT_RESET, TPM_RESET);
            1: apply_setting($urandom_range(0, 50), $urandom_range(100, 5000), $urandom());
            2: begin
               apply_setting($urandom(), $urandom_range(1, 32'hFFFF_FFFF),
                             $urandom_range(1, 32'hFFFF_FFFF));
               write_csr(CSR_SPARE, $urandom());
            end
            3: apply_setting('0, '1, '1);
            4: apply_setting('1, 32'd1, 32'd1);
            7: apply_setting($urandom_range(0, 2000), $urandom_range(2001, 1000000), '0);
            default: apply_setting($urandom_range(0, 10000), $urandom_range(10000, 2000000),
                                   $urandom_range(1, 200000000));
         endcase
         stamp_now = $urandom();
         steady    = (phase == 6);
         goal      = items_sent + PHASE_ITEMS;
         while (items_sent < goal) run_burst();
      end
      steady = 1'b0;
   endtask

   // reading side holds off while requests keep coming, so the input stalls
   task test_output_backpressure();
      int goal;
      wait_for_drain();
      apply_setting(32'd100, TIMEOUT_RESET, TPM_RESET);
      steady       = 1'b1;
      hold_request = HOLD_CYCLES;
      goal         = items_sent + PRESSURE_ITEMS;
      while (items_sent < goal) run_burst();
      steady = 1'b0;
   endtask

   initial begin : result_sink
      int          stall_left;
      int          hold_left;
      reading_type want;
      stall_left   = 0;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            readings_seen++;
            if (expected_readings.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected reading transfer, rpm %0d", $time, rsp_ch.rpm);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_ch.rpm !== want.rpm) begin
                  mismatches++;
                  $display("%0t: rpm expected %0d, actual %0d", $time, want.rpm, rsp_ch.rpm);
               end
               if (rsp_ch.running !== want.running) begin
                  mismatches++;
                  $display("%0t: running expected %0b, actual %0b",
                           $time, want.running, rsp_ch.running);
               end
               if (rsp_ch.changed !== want.changed) begin
                  mismatches++;
                  $display("%0t: changed expected %0b, actual %0b",
                           $time, want.changed, rsp_ch.changed);
               end
            end
            stall_left = steady ? 0 : $urandom_range(0, GAP_MAX);
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_DEBOUNCE;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_EDGE;
      req_ch.time_us = '0;
      cfg_debounce   = DEBOUNCE_RESET;
      cfg_timeout    = TIMEOUT_RESET;
      cfg_tpm        = TPM_RESET;
      edge_stamp     = '0;
      period_us      = '0;
      last_rpm       = RPM_SENTINEL;
      stamp_now      = '0;
      steady         = 1'b0;
      hold_request   = 0;
      items_sent     = 0;
      readings_seen  = 0;
      csr_writes     = 0;
      mismatches     = 0;
      idle_cycles    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_defaults();
      test_directed_extremes();
      test_random_traffic();
      test_output_backpressure();
      wait_for_drain();

      $display("Sent %0d edges and samples, compared %0d readings, %0d register writes.",
               items_sent, readings_seen, csr_writes);
      $display("Covered debounce and timeout edges, time wraparound, extreme settings, stalls.");
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
